// ----- rtl/core/tt_pkg.sv -----
// Shared types and constants of the tap tempo tracker.
// No dependencies; imported by tt_divider and tap_tempo_tracker.
`timescale 1ns / 1ps

package tt_pkg;

  // Default interval counter width.
  localparam int COUNT_BITS_DEF = 21;

  // The dividend sample_rate * 15360 fits in 32 bits for any 18-bit rate.
  localparam int NUM_BITS = 32;

  localparam int RATE_BITS = 18;
  localparam int LIMIT_BITS = 20;
  localparam int CFG_DATA_BITS = 20;
  localparam int CFG_IDX_BITS = 2;
  localparam int BLK_BITS = 11;
  localparam int TEMPO_BITS = 16;
  localparam int POS_BITS = 19;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd2;

  // Register reset values.
  localparam logic [RATE_BITS-1:0] SAMPLE_RATE_RESET = 18'd48000;
  localparam logic [LIMIT_BITS-1:0] MIN_INTERVAL_RESET = 20'd2400;
  localparam logic [LIMIT_BITS-1:0] TIMEOUT_RESET = 20'd144000;

  // Tempo in Q8.8 BPM: 120 at reset, clamped to 40..240.
  localparam logic [TEMPO_BITS-1:0] TEMPO_RESET = 16'd30720;
  localparam logic [TEMPO_BITS-1:0] TEMPO_MIN = 16'd10240;
  localparam logic [TEMPO_BITS-1:0] TEMPO_MAX = 16'd61440;

  typedef struct packed {
    logic                tap_edge;
    logic [BLK_BITS-1:0] block_samples;
  } tt_in_t;

  typedef struct packed {
    logic [TEMPO_BITS-1:0] tempo_q8;
    logic [POS_BITS-1:0]   period_samples;
    logic [POS_BITS-1:0]   pulse_position;
    logic                  tapping_now;
  } tt_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/tt_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on tt_pkg for NUM_BITS, the default width and the status struct.
`timescale 1ns / 1ps

module tt_divider #(
  parameter int DIV_BITS = tt_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tt_pkg::NUM_BITS-1:0] numer,
  input  logic [DIV_BITS-1:0]         divisor,
  output tt_pkg::div_stat_t           stat,
  output logic [tt_pkg::NUM_BITS-1:0] quotient
);
  import tt_pkg::*;

  localparam int STEP_W = $clog2(NUM_BITS);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [DIV_BITS-1:0] rem;
  logic [NUM_BITS-1:0] acc;
  logic [DIV_BITS-1:0] dvs;
  logic                dvs_zero;

  logic [DIV_BITS+1:0] trial;
  logic [DIV_BITS:0]   shifted;
  logic                ge;

  assign shifted = {rem, acc[NUM_BITS-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign ge      = !trial[DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step     <= STEP_W'(NUM_BITS - 1);
      rem      <= '0;
      acc      <= numer;
      dvs      <= divisor;
      dvs_zero <= (divisor == '0);
    end else if (busy) begin
      step <= step - 1'b1;
      acc  <= {acc[NUM_BITS-2:0], ge};
      rem  <= ge ? trial[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
    end
  end

  // Division by zero reports zero.
  assign quotient  = dvs_zero ? '0 : acc;
  assign stat.busy = busy;
  assign stat.done = done;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still stepping");

endmodule

// ----- rtl/core/tap_tempo_tracker.sv -----
// Top level of the tap tempo tracker: sequencer, state and handshakes.
// Depends on tt_pkg and tt_divider.
`timescale 1ns / 1ps
//
//  channel  dir   handshake              payload
//  -------  ----  ---------------------  --------------------------------------
//  in       in    in_valid / in_stall    tt_in_t: tap_edge, block_samples
//  out      out   out_valid / out_stall  tt_out_t: tempo, period, position, tap
//  cfg      in    cfg_we                 cfg_index, cfg_data (20 bits)
//
//  Each item transfers in, then runs one 32-step division for the beat period
//  (tempo register into sample_rate * 15360) and, when a tap is taken, a
//  second 32-step division for the new tempo. Both share one serial divider,
//  so the tempo division follows the period division, and out_stall can
//  add a wait. in_stall is high from the transfer until the result is
//  loaded into the output register; the next item transfers while that
//  result still waits. Reset is synchronous and needs no clearing pass.

module tap_tempo_tracker #(
  parameter int COUNT_BITS = tt_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tt_pkg::tt_in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tt_pkg::tt_out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [tt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tt_pkg::*;

  localparam int DIV_BITS = (COUNT_BITS > TEMPO_BITS) ? COUNT_BITS : TEMPO_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PERIOD = 2'd1;
  localparam logic [1:0] S_TEMPO  = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  // Configuration registers.
  logic [RATE_BITS-1:0]  sample_rate;
  logic [LIMIT_BITS-1:0] min_interval;
  logic [LIMIT_BITS-1:0] timeout_samples;

  // Tracker state.
  logic [1:0]            state;
  logic [COUNT_BITS-1:0] interval_count;
  logic                  tap_active;
  logic                  average_active;
  logic [TEMPO_BITS-1:0] tempo_reg;
  logic [POS_BITS-1:0]   beat_position;

  // Per-item working registers.
  logic                  edge_q;
  logic [POS_BITS-1:0]   pos_start;
  logic [NUM_BITS-1:0]   period;

  logic                  in_take;
  logic                  div_start;
  logic [DIV_BITS-1:0]   div_divisor;
  div_stat_t             div_stat;
  logic [NUM_BITS-1:0]   quot;
  logic [NUM_BITS-1:0]   numer;
  logic [RATE_BITS+3:0]  rate_x15;

  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] count_sat;
  logic                  tap_take;
  logic                  timed_out;
  logic [NUM_BITS:0]     avg_sum;
  logic [NUM_BITS-1:0]   tempo_raw;
  logic [TEMPO_BITS-1:0] tempo_next;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // sample_rate * 15360 = (sample_rate * 15) << 10
  assign rate_x15 = {sample_rate, 4'b0000} - {4'b0000, sample_rate};
  assign numer    = {rate_x15, 10'b0};

  // Saturating interval count after adding this block.
  assign count_sum = {1'b0, interval_count} + (COUNT_BITS + 1)'(in_data.block_samples);
  assign count_sat = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];

  assign tap_take  = tap_active && edge_q &&
                     (NUM_BITS'(interval_count) > NUM_BITS'(min_interval));
  assign timed_out = !edge_q && (NUM_BITS'(interval_count) > NUM_BITS'(timeout_samples));

  // New tempo: average with the old one after the first interval, then clamp.
  assign avg_sum   = {1'b0, quot} + (NUM_BITS + 1)'(tempo_reg);
  assign tempo_raw = average_active ? avg_sum[NUM_BITS:1] : quot;

  always_comb begin
    priority if (tempo_raw < NUM_BITS'(TEMPO_MIN)) begin
      tempo_next = TEMPO_MIN;
    end else if (tempo_raw > NUM_BITS'(TEMPO_MAX)) begin
      tempo_next = TEMPO_MAX;
    end else begin
      tempo_next = tempo_raw[TEMPO_BITS-1:0];
    end
  end

  // Divider is started with the tempo on transfer, with the count for a tap.
  assign div_start   = in_take || ((state == S_PERIOD) && div_stat.done && tap_take);
  assign div_divisor = in_take ? DIV_BITS'(tempo_reg) : DIV_BITS'(interval_count);

  tt_divider #(
    .DIV_BITS (DIV_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quot)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate     <= SAMPLE_RATE_RESET;
      min_interval    <= MIN_INTERVAL_RESET;
      timeout_samples <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate     <= cfg_data[RATE_BITS-1:0];
        REG_MIN_INTERVAL: min_interval    <= cfg_data[LIMIT_BITS-1:0];
        REG_TIMEOUT:      timeout_samples <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and tracker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      interval_count <= '0;
      tap_active     <= 1'b0;
      average_active <= 1'b0;
      tempo_reg      <= TEMPO_RESET;
      beat_position  <= '0;
      out_valid      <= 1'b0;
    end else begin
      // Drop valid after its transfer unless a new result is loaded now.
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // Latch the block and advance both counters at the transfer.
          if (in_take) begin
            edge_q         <= in_data.tap_edge;
            pos_start      <= beat_position;
            interval_count <= count_sat;
            beat_position  <= beat_position + POS_BITS'(in_data.block_samples);
            state          <= S_PERIOD;
          end
        end
        S_PERIOD: begin
          if (div_stat.done) begin
            period <= quot;
            // The pulse wraps on the period from the tempo at block start.
            if (NUM_BITS'(beat_position) >= quot) begin
              beat_position <= '0;
            end
            priority if (tap_take) begin
              state <= S_TEMPO;
            end else if (tap_active) begin
              // Early tap is ignored; without a tap the timeout may end tapping.
              if (timed_out) begin
                tap_active     <= 1'b0;
                average_active <= 1'b0;
                interval_count <= '0;
              end
              state <= S_OUT;
            end else begin
              if (edge_q) begin
                tap_active     <= 1'b1;
                average_active <= 1'b0;
                interval_count <= '0;
              end
              state <= S_OUT;
            end
          end
        end
        S_TEMPO: begin
          if (div_stat.done) begin
            tempo_reg      <= tempo_next;
            average_active <= 1'b1;
            interval_count <= '0;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_data.tempo_q8       <= tempo_reg;
      out_data.period_samples <= period[POS_BITS-1:0];
      out_data.pulse_position <= pos_start;
      out_data.tapping_now    <= tap_active;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_PERIOD) || (state == S_TEMPO))
    else $error("divider result arrived outside a wait state");
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_PERIOD) && div_stat.busy)
    else $error("transfer did not start the period division");
  a_tempo_range: assert property (@(posedge clk) disable iff (rst)
    (tempo_reg >= TEMPO_MIN) && (tempo_reg <= TEMPO_MAX))
    else $error("tempo left the clamp range");
  a_avg_needs_tap: assert property (@(posedge clk) disable iff (rst)
    !tap_active |-> !average_active)
    else $error("averaging active outside tapping mode");

endmodule
